// ===== rtl/core/depth_pixel_to_world_point_defines.svh =====
// Assertion macros shared by the depth-to-world-point design.
`ifndef DEPTH_PIXEL_TO_WORLD_POINT_DEFINES_SVH
`define DEPTH_PIXEL_TO_WORLD_POINT_DEFINES_SVH
`ifndef SYNTHESIS
`define DPW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");
`define DPW_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define DPW_ASSERT(lbl, clk, rst_n, prop)
`define DPW_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/dpw_pkg.sv =====
// Types and constants shared by the depth-to-world-point design.
package dpw_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam int POSE_WORDS = 12;
    localparam int POSE_ROWS  = 3;
    localparam int POSE_COLS  = 4;

    localparam int FRAC_SHIFT  = 16;
    localparam int COLOR_SHIFT = 8;

    localparam int RCP_STEPS = 24;
    localparam int RCP_LAT   = RCP_STEPS + 1;
    localparam logic [23:0] RCP_INIT    = 24'd256;
    localparam logic [23:0] RCP_SAT_LIM = 24'd256;
    localparam logic [23:0] DEPTH_MAX   = 24'hFFFFFF;

    localparam int CAM_STEPS = 31;
    localparam int CAM_LAT   = CAM_STEPS + 2;

    // Pipeline stage numbers of the back end.
    localparam int K_CAM_IN = RCP_LAT + 1;
    localparam int K_POSE   = K_CAM_IN + CAM_LAT;
    localparam int K_RAM_RD = K_POSE - 1;
    localparam int K_PROD   = K_POSE + 1;
    localparam int K_LAST   = K_POSE + 2;

    typedef enum logic [2:0] {
        CFG_FOCAL_X  = 3'd0,
        CFG_FOCAL_Y  = 3'd1,
        CFG_CENTER_X = 3'd2,
        CFG_CENTER_Y = 3'd3,
        CFG_MIN_DEPTH = 3'd4,
        CFG_MAX_DEPTH = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic               kind;
        logic [7:0]         frame;
        logic [3:0]         pose_word;
        logic signed [31:0] pose_value;
        logic [11:0]        pixel_u;
        logic [11:0]        pixel_v;
        logic [23:0]        inverse_depth;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic [23:0]        packed_color;
    } t_out_item;

    typedef struct packed {
        logic [15:0] focal_x;
        logic [15:0] focal_y;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [23:0] min_depth;
        logic [23:0] max_depth;
    } t_cam_cfg;

    typedef struct packed {
        logic     load_ok;
        logic     point_ok;
        t_in_item item;
    } t_qent;

    typedef struct packed {
        logic  vld;
        t_qent ent;
    } t_q_head;

    typedef struct packed {
        t_qent       ent;
        logic        keep;
        logic [23:0] depth;
    } t_side;

    typedef struct packed {
        logic take;
        logic pose_we;
        logic last_keep;
    } t_back_sts;

endpackage

// ===== rtl/core/dpw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dpw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/dpw_front.sv =====
// Front end: accepts items, sorts out those that do nothing, queues the rest.
module dpw_front import dpw_pkg::*; #(
    parameter int FRAME_SLOTS = 256
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    input  logic     i_take,
    output t_q_head  o_head
);

    t_qent             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;

    logic  frame_ok;
    logic  accept;
    logic  enq;
    t_qent ent;

    assign frame_ok = 32'(i_item.frame) < FRAME_SLOTS;
    assign ent.item = i_item;
    assign ent.load_ok = !i_item.kind && frame_ok && (32'(i_item.pose_word) < POSE_WORDS);
    assign ent.point_ok = i_item.kind && frame_ok && (i_item.inverse_depth != '0);

    assign o_full = (r_cnt == QCNT_W'(QDEPTH));
    assign accept = i_push && !o_full;
    // An item that would only be discarded later is taken and dropped here.
    assign enq = accept && (ent.load_ok || ent.point_ok);

    always_comb begin
        case ({enq, i_take})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (enq) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_take) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_mem[r_wp] <= ent;
        end
    end

    assign o_head.vld = (r_cnt != '0);
    assign o_head.ent = r_mem[r_rp];

endmodule

// ===== rtl/core/dpw_recip.sv =====
// Pipelined reciprocal of the inverse depth, one quotient bit per stage.
module dpw_recip import dpw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [23:0] i_inv,
    output logic [23:0] o_depth
);

    logic [23:0]          r_rem [RCP_STEPS];
    logic [23:0]          r_q   [RCP_STEPS];
    logic [23:0]          r_div [RCP_STEPS];
    logic [RCP_STEPS-1:0] r_sat;
    logic [23:0]          r_depth;

    logic [23:0]          n_rem [RCP_STEPS];
    logic [23:0]          n_q   [RCP_STEPS];
    logic [23:0]          n_div [RCP_STEPS];
    logic [RCP_STEPS-1:0] n_sat;

    // The quotient saturates when the inverse depth is 256 or less, so every
    // other quotient fits 24 bits and the remainder starts at 2^32 >> 24.
    always_comb begin
        logic [23:0] rem_in;
        logic [23:0] q_in;
        logic [24:0] trial;
        logic        ge;
        for (int j = 0; j < RCP_STEPS; j++) begin
            if (j == 0) begin
                rem_in   = RCP_INIT;
                q_in     = '0;
                n_div[j] = i_inv;
                n_sat[j] = (i_inv <= RCP_SAT_LIM);
            end else begin
                rem_in   = r_rem[j-1];
                q_in     = r_q[j-1];
                n_div[j] = r_div[j-1];
                n_sat[j] = r_sat[j-1];
            end
            trial    = {rem_in, 1'b0};
            ge       = (trial >= {1'b0, n_div[j]});
            n_rem[j] = ge ? 24'(trial - {1'b0, n_div[j]}) : trial[23:0];
            n_q[j]   = {q_in[22:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < RCP_STEPS; j++) begin
                r_rem[j] <= n_rem[j];
                r_q[j]   <= n_q[j];
                r_div[j] <= n_div[j];
            end
            r_sat   <= n_sat;
            r_depth <= r_sat[RCP_STEPS-1] ? DEPTH_MAX : r_q[RCP_STEPS-1];
        end
    end

    assign o_depth = r_depth;

endmodule

// ===== rtl/core/dpw_cam_div.sv =====
// Pipelined signed division of a scaled pixel offset by a focal length.
module dpw_cam_div import dpw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [42:0] i_prod,
    input  logic [15:0]        i_focal,
    output logic signed [31:0] o_t
);

    logic [15:0] r_a_rem;
    logic [30:0] r_a_rest;
    logic [15:0] r_a_f;
    logic        r_a_neg;
    logic        r_a_ovf;

    logic [15:0]          r_rem  [CAM_STEPS];
    logic [30:0]          r_rest [CAM_STEPS];
    logic [30:0]          r_q    [CAM_STEPS];
    logic [15:0]          r_f    [CAM_STEPS];
    logic [CAM_STEPS-1:0] r_neg;
    logic [CAM_STEPS-1:0] r_ovf;
    logic signed [31:0]   r_t;

    logic [15:0] n_rem  [CAM_STEPS];
    logic [30:0] n_rest [CAM_STEPS];
    logic [30:0] n_q    [CAM_STEPS];

    logic [42:0] mag;
    logic [43:0] dividend;
    logic [15:0] focal;
    logic        ovf;
    logic [30:0] q_last;

    // The magnitude stays below 2^40; the dividend is that times sixteen.
    assign mag      = i_prod[42] ? 43'(-i_prod) : 43'(i_prod);
    assign dividend = {mag[39:0], 4'b0};
    assign focal    = (i_focal == '0) ? 16'd1 : i_focal;
    assign ovf      = ({3'b0, dividend} >= {focal, 31'b0});

    always_comb begin
        logic [15:0] rem_in;
        logic [30:0] rest_in;
        logic [30:0] q_in;
        logic [15:0] f_in;
        logic [16:0] trial;
        logic        ge;
        for (int j = 0; j < CAM_STEPS; j++) begin
            if (j == 0) begin
                rem_in  = r_a_rem;
                rest_in = r_a_rest;
                q_in    = '0;
                f_in    = r_a_f;
            end else begin
                rem_in  = r_rem[j-1];
                rest_in = r_rest[j-1];
                q_in    = r_q[j-1];
                f_in    = r_f[j-1];
            end
            trial     = {rem_in, rest_in[30]};
            ge        = (trial >= {1'b0, f_in});
            n_rem[j]  = ge ? 16'(trial - {1'b0, f_in}) : trial[15:0];
            n_rest[j] = {rest_in[29:0], 1'b0};
            n_q[j]    = {q_in[29:0], ge};
        end
    end

    assign q_last = r_q[CAM_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_rem  <= {3'b0, dividend[43:31]};
            r_a_rest <= dividend[30:0];
            r_a_f    <= focal;
            r_a_neg  <= i_prod[42];
            r_a_ovf  <= ovf;
            for (int j = 0; j < CAM_STEPS; j++) begin
                r_rem[j]  <= n_rem[j];
                r_rest[j] <= n_rest[j];
                r_q[j]    <= n_q[j];
                r_f[j]    <= (j == 0) ? r_a_f : r_f[j-1];
                r_neg[j]  <= (j == 0) ? r_a_neg : r_neg[j-1];
                r_ovf[j]  <= (j == 0) ? r_a_ovf : r_ovf[j-1];
            end
            if (r_ovf[CAM_STEPS-1]) begin
                r_t <= r_neg[CAM_STEPS-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
            end else begin
                r_t <= r_neg[CAM_STEPS-1] ? $signed(32'(-{1'b0, q_last}))
                                          : $signed({1'b0, q_last});
            end
        end
    end

    assign o_t = r_t;

endmodule

// ===== rtl/core/dpw_back.sv =====
// Back end: depth, camera coordinates, pose transform and pose table writes.
module dpw_back import dpw_pkg::*; #(
    parameter int FRAME_SLOTS = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  t_q_head   i_head,
    input  t_cam_cfg  i_cfg,
    output t_out_item o_res,
    output t_back_sts o_sts
);

    localparam int AW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;

    logic [K_LAST:0] r_vld;
    t_side           r_side [K_LAST+1];

    logic signed [42:0] r_px;
    logic signed [42:0] r_py;
    logic signed [63:0] r_prod  [POSE_ROWS][POSE_ROWS];
    logic signed [31:0] r_trans [POSE_ROWS];
    logic signed [49:0] r_sum   [POSE_ROWS];

    logic [23:0]        depth;
    logic               keep;
    t_side              cam_side;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tv [POSE_ROWS];
    logic signed [31:0] pose [POSE_WORDS];
    logic               we_base;
    logic [AW-1:0]      ram_addr;

    assign o_sts.take = i_adv && i_head.vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[K_LAST-1:0], i_head.vld};
        end
    end

    // Depth and the range check are filled in once the reciprocal is out.
    always_comb begin
        cam_side       = r_side[RCP_LAT];
        cam_side.keep  = keep;
        cam_side.depth = depth;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side[0].ent   <= i_head.ent;
            r_side[0].keep  <= 1'b0;
            r_side[0].depth <= '0;
            for (int k = 1; k <= K_LAST; k++) begin
                r_side[k] <= (k == K_CAM_IN) ? cam_side : r_side[k-1];
            end
            r_px <= $signed({1'b0, depth}) * dx;
            r_py <= $signed({1'b0, depth}) * dy;
        end
    end

    dpw_recip u_recip (
        .i_clk   (i_clk),
        .i_en    (i_adv),
        .i_inv   (r_side[0].ent.item.inverse_depth),
        .o_depth (depth)
    );

    assign keep = r_side[RCP_LAT].ent.point_ok
               && (depth >= i_cfg.min_depth) && (depth <= i_cfg.max_depth);
    assign dx = $signed({2'b0, r_side[RCP_LAT].ent.item.pixel_u, 4'b0})
              - $signed({2'b0, i_cfg.center_x});
    assign dy = $signed({2'b0, r_side[RCP_LAT].ent.item.pixel_v, 4'b0})
              - $signed({2'b0, i_cfg.center_y});

    dpw_cam_div u_div_x (
        .i_clk   (i_clk),
        .i_en    (i_adv),
        .i_prod  (r_px),
        .i_focal (i_cfg.focal_x),
        .o_t     (tx)
    );

    dpw_cam_div u_div_y (
        .i_clk   (i_clk),
        .i_en    (i_adv),
        .i_prod  (r_py),
        .i_focal (i_cfg.focal_y),
        .o_t     (ty)
    );

    // Loads write at the same stage where points read, so order is kept.
    assign we_base  = i_adv && r_vld[K_RAM_RD] && r_side[K_RAM_RD].ent.load_ok;
    assign ram_addr = AW'(r_side[K_RAM_RD].ent.item.frame);
    assign o_sts.pose_we = we_base;

    for (genvar w = 0; w < POSE_WORDS; w++) begin : g_pose
        logic [31:0] rdata;
        dpw_ram #(
            .WIDTH (32),
            .DEPTH (FRAME_SLOTS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we_base && (r_side[K_RAM_RD].ent.item.pose_word == 4'(w))),
            .i_waddr (ram_addr),
            .i_wdata (r_side[K_RAM_RD].ent.item.pose_value),
            .i_re    (i_adv),
            .i_raddr (ram_addr),
            .o_rdata (rdata)
        );
        assign pose[w] = $signed(rdata);
    end

    assign tv[0] = tx;
    assign tv[1] = ty;
    assign tv[2] = $signed({4'b0, r_side[K_POSE].depth, 4'b0});

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int r = 0; r < POSE_ROWS; r++) begin
                for (int c = 0; c < POSE_ROWS; c++) begin
                    r_prod[r][c] <= pose[r*POSE_COLS + c] * tv[c];
                end
                r_trans[r] <= pose[r*POSE_COLS + POSE_ROWS];
                r_sum[r] <= 50'(r_prod[r][0] >>> FRAC_SHIFT)
                          + 50'(r_prod[r][1] >>> FRAC_SHIFT)
                          + 50'(r_prod[r][2] >>> FRAC_SHIFT)
                          + 50'(r_trans[r]);
            end
        end
    end

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] res;
        if (v > 50'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -50'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = 32'(v);
        end
        return res;
    endfunction

    assign o_res.world_x = sat32(r_sum[0]);
    assign o_res.world_y = sat32(r_sum[1]);
    assign o_res.world_z = sat32(r_sum[2]);
    assign o_res.packed_color = {r_side[K_LAST].ent.item.red,
                                 r_side[K_LAST].ent.item.green,
                                 r_side[K_LAST].ent.item.blue};
    assign o_sts.last_keep = r_vld[K_LAST] && r_side[K_LAST].keep;

endmodule

// ===== rtl/core/depth_pixel_to_world_point.sv =====
// Top level of the inverse-depth pixel to world point back-projector.
//
// Items enter through a queue-like port: push with full, payload in i_item.
// A load item writes one of the twelve pose words of a frame slot; a point
// item yields at most one world point, read from o_result while empty is
// low and taken with pop. Points with zero inverse depth, an unknown frame
// slot or a depth outside the configured range leave no result.
// The block takes one item per cycle while full is low. An accepted point
// reaches o_result through the bit-per-stage reciprocal (25 stages), the
// bit-per-stage focal division (33 stages) and the pose multiply, add and
// saturate stages. A four-entry queue parts the front from the back; when
// a result is not taken the back pipeline holds and the queue fills, then
// full rises. Configuration writes go through i_cfg_valid/o_cfg_ready,
// index and data; the user must make them only while no item is in flight,
// which the block does not enforce. Reset clears the control state and
// loads the camera defaults; pose words are unknown until loaded.
`include "depth_pixel_to_world_point_defines.svh"
module depth_pixel_to_world_point import dpw_pkg::*; #(
    parameter int FRAME_SLOTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  t_in_item    i_item,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cam_cfg  r_cfg;
    logic      r_out_vld;
    t_out_item r_out;

    t_q_head   fr_head;
    t_back_sts bk_sts;
    t_out_item bk_res;
    logic      w_adv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x   <= 16'd8192;
            r_cfg.focal_y   <= 16'd8192;
            r_cfg.center_x  <= 16'd5120;
            r_cfg.center_y  <= 16'd3840;
            r_cfg.min_depth <= 24'd0;
            r_cfg.max_depth <= DEPTH_MAX;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FOCAL_X:   r_cfg.focal_x   <= i_cfg_data[15:0];
                CFG_FOCAL_Y:   r_cfg.focal_y   <= i_cfg_data[15:0];
                CFG_CENTER_X:  r_cfg.center_x  <= i_cfg_data[15:0];
                CFG_CENTER_Y:  r_cfg.center_y  <= i_cfg_data[15:0];
                CFG_MIN_DEPTH: r_cfg.min_depth <= i_cfg_data[23:0];
                CFG_MAX_DEPTH: r_cfg.max_depth <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    dpw_front #(
        .FRAME_SLOTS (FRAME_SLOTS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .i_take  (bk_sts.take),
        .o_head  (fr_head)
    );

    // The whole back pipeline moves whenever the output register can load.
    assign w_adv = !r_out_vld || pop;

    dpw_back #(
        .FRAME_SLOTS (FRAME_SLOTS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_head  (fr_head),
        .i_cfg   (r_cfg),
        .o_res   (bk_res),
        .o_sts   (bk_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= bk_sts.last_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && bk_sts.last_keep) begin
            r_out <= bk_res;
        end
    end

    assign empty    = !r_out_vld;
    assign o_result = r_out;

    `DPW_ASSERT(a_result_from_point, i_clk, i_rst_n, $rose(!empty) |-> $past(bk_sts.last_keep))
    `DPW_ASSERT(a_pose_write_moves, i_clk, i_rst_n, bk_sts.pose_we |-> w_adv)
    `DPW_ASSERT_NEVER(a_full_has_head, i_clk, i_rst_n, full && !fr_head.vld)

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the inverse-depth pixel to world point block.
module tb;
    import dpw_pkg::*;

    localparam int SLOTS      = 256;
    localparam int TAIL_WAIT  = 80;
    localparam int IDLE_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    t_in_item    i_item = '0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = CFG_FOCAL_X;
    logic [31:0] i_cfg_data = '0;
    logic        full, empty, o_cfg_ready;
    t_out_item   o_result;

    depth_pixel_to_world_point #(.FRAME_SLOTS(SLOTS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .i_item(i_item), .full(full),
        .empty(empty), .pop(pop), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Camera settings and pose store as the block should hold them.
    logic [15:0] focal_x = 16'd8192, focal_y = 16'd8192;
    logic [15:0] center_x = 16'd5120, center_y = 16'd3840;
    logic [23:0] min_depth = 24'd0, max_depth = 24'hFFFFFF;
    logic [31:0] pose_store [SLOTS*POSE_WORDS];
    bit          pose_written [SLOTS*POSE_WORDS];
    int          ready_frames [$];

    t_out_item   expected_points [$];
    int          errors = 0;
    int          points_seen = 0;
    int          items_sent = 0;
    int          cfg_writes = 0;
    bit          steady_send = 1'b0;
    bit          steady_take = 1'b0;
    int          stall_left = 0;
    int          idle_cycles = 0;

    function automatic longint clamp_q16(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic bit world_point_of(t_in_item it, output t_out_item pt);
        longint unsigned dq;
        longint          cam [3];
        longint          diff, f, acc;
        logic [31:0]     coord [3];
        int              base;
        pt = '0;
        if (it.inverse_depth == 0) return 1'b0;
        dq = 64'h1_0000_0000 / longint'(it.inverse_depth);
        if (dq > 64'hFFFFFF) dq = 64'hFFFFFF;
        if (dq < min_depth || dq > max_depth) return 1'b0;
        diff = longint'(it.pixel_u) * 16 - longint'(center_x);
        f = (focal_x == 0) ? 1 : longint'(focal_x);
        cam[0] = clamp_q16(longint'(dq) * diff * 16 / f);
        diff = longint'(it.pixel_v) * 16 - longint'(center_y);
        f = (focal_y == 0) ? 1 : longint'(focal_y);
        cam[1] = clamp_q16(longint'(dq) * diff * 16 / f);
        cam[2] = longint'(dq) * 16;
        base = it.frame * POSE_WORDS;
        for (int r = 0; r < POSE_ROWS; r++) begin
            acc = longint'($signed(pose_store[base + r*POSE_COLS + 3]));
            // Each product is floored to Q16.16 before the exact sum.
            for (int c = 0; c < 3; c++)
                acc += (longint'($signed(pose_store[base + r*POSE_COLS + c])) * cam[c])
                       >>> FRAC_SHIFT;
            coord[r] = 32'(clamp_q16(acc));
        end
        pt.world_x = coord[0];
        pt.world_y = coord[1];
        pt.world_z = coord[2];
        pt.packed_color = {it.red, it.green, it.blue};
        return 1'b1;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady_send || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    task automatic send_item(t_in_item it);
        t_out_item pt;
        int        g;
        int        slot;
        push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        items_sent++;
        if (it.kind == 1'b0) begin
            if (it.pose_word < POSE_WORDS) begin
                slot = it.frame * POSE_WORDS + it.pose_word;
                pose_store[slot] = it.pose_value;
                if (!pose_written[slot]) begin
                    pose_written[slot] = 1'b1;
                    if (frame_ready(it.frame)) ready_frames = {ready_frames, int'(it.frame)};
                end
            end
        end else if (world_point_of(it, pt)) begin
            expected_points = {expected_points, pt};
        end
        g = gap_len();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    function automatic bit frame_ready(int fr);
        for (int w = 0; w < POSE_WORDS; w++)
            if (!pose_written[fr*POSE_WORDS + w]) return 1'b0;
        return 1'b1;
    endfunction

    // Lets every result out and gives the pipeline time to finish dropped points.
    task automatic drain();
        push <= 1'b0;
        while (expected_points.size() > 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_FOCAL_X:   focal_x = value[15:0];
            CFG_FOCAL_Y:   focal_y = value[15:0];
            CFG_CENTER_X:  center_x = value[15:0];
            CFG_CENTER_Y:  center_y = value[15:0];
            CFG_MIN_DEPTH: min_depth = value[23:0];
            CFG_MAX_DEPTH: max_depth = value[23:0];
            default: ;
        endcase
    endtask

    function automatic t_in_item pose_load(int fr, int w, logic [31:0] v);
        t_in_item it;
        it = '0;
        it.kind = 1'b0;
        it.frame = 8'(fr);
        it.pose_word = 4'(w);
        it.pose_value = v;
        it.pixel_u = 12'($urandom);
        it.pixel_v = 12'($urandom);
        it.inverse_depth = 24'($urandom);
        return it;
    endfunction

    function automatic t_in_item point_item(int fr, int u, int v, logic [23:0] inv);
        t_in_item it;
        it = '0;
        it.kind = 1'b1;
        it.frame = 8'(fr);
        it.pose_word = 4'($urandom);
        it.pose_value = $urandom;
        it.pixel_u = 12'(u);
        it.pixel_v = 12'(v);
        it.inverse_depth = inv;
        it.red = 8'($urandom);
        it.green = 8'($urandom);
        it.blue = 8'($urandom);
        return it;
    endfunction

    function automatic logic [31:0] random_pose_value();
        if ($urandom_range(0, 99) < 20) return $urandom;
        return $urandom_range(0, 32'h3FFFF) - 32'h20000;
    endfunction

    function automatic logic [23:0] random_inverse_depth();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 24'($urandom_range(1, 255));
        if (r < 13) return 24'd0;
        if (r < 22) return 24'($urandom);
        return 24'($urandom_range(24'h020000, 24'h7FFFFF));
    endfunction

    // Mostly points on loaded frames, with whole pose loads, ignored pose
    // words and stray rewrites mixed in.
    task automatic random_traffic(int count);
        int n, r, fr;
        n = 0;
        while (n < count) begin
            r = $urandom_range(0, 99);
            if (r < 6 || ready_frames.size() == 0) begin
                fr = $urandom_range(0, SLOTS - 1);
                for (int w = 0; w < POSE_WORDS; w++)
                    send_item(pose_load(fr, w, random_pose_value()));
                n += POSE_WORDS;
            end else if (r < 10) begin
                send_item(pose_load($urandom_range(0, SLOTS - 1), $urandom_range(12, 15),
                                    $urandom));
            end else if (r < 14) begin
                fr = ready_frames[$urandom_range(0, ready_frames.size() - 1)];
                send_item(pose_load(fr, $urandom_range(0, 11), random_pose_value()));
                n++;
            end else begin
                fr = ready_frames[$urandom_range(0, ready_frames.size() - 1)];
                send_item(point_item(fr, $urandom_range(0, 4095), $urandom_range(0, 4095),
                                     random_inverse_depth()));
                n++;
            end
        end
    endtask

    task automatic test_directed();
        logic [31:0] words [POSE_WORDS];
        words = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                  32'hFFFF_0000, 32'h0000_8000, 32'h0002_0000, 32'h7FFF_FFFF,
                  32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000};
        steady_send = 1'b1;
        for (int w = 0; w < POSE_WORDS; w++) send_item(pose_load(0, w, words[w]));
        // A word index beyond the matrix is ignored.
        send_item(pose_load(255, 13, 32'hDEAD_BEEF));
        send_item(point_item(0, 0, 0, 24'd0));
        send_item(point_item(0, 0, 0, 24'd1));
        send_item(point_item(0, 4095, 4095, 24'hFFFFFF));
        send_item(point_item(0, 4095, 0, 24'h100000));
        send_item(point_item(0, 0, 4095, 24'h000100));
        send_item(point_item(0, 320, 240, 24'h080000));
        send_item(point_item(0, 2048, 1024, 24'h000101));
        steady_send = 1'b0;
        drain();
    endtask

    task automatic test_intrinsics();
        for (int k = 0; k < 3; k++) begin
            write_reg(CFG_FOCAL_X, $urandom_range(256, 65535));
            write_reg(CFG_FOCAL_Y, $urandom_range(256, 65535));
            write_reg(CFG_CENTER_X, $urandom);
            write_reg(CFG_CENTER_Y, $urandom);
            random_traffic(100);
        end
    endtask

    task automatic test_extremes();
        write_reg(CFG_FOCAL_X, 32'd0);
        write_reg(CFG_FOCAL_Y, 32'd1);
        write_reg(CFG_CENTER_X, 32'hFFFF);
        write_reg(CFG_CENTER_Y, 32'd0);
        random_traffic(75);
        write_reg(CFG_FOCAL_X, 32'hFFFF);
        write_reg(CFG_FOCAL_Y, 32'd0);
        write_reg(CFG_CENTER_X, 32'd0);
        write_reg(CFG_CENTER_Y, 32'hFFFF);
        random_traffic(75);
    endtask

    task automatic test_depth_window();
        write_reg(CFG_FOCAL_X, 32'd8192);
        write_reg(CFG_FOCAL_Y, 32'd6000);
        write_reg(CFG_MIN_DEPTH, 32'h000800);
        write_reg(CFG_MAX_DEPTH, 32'h00C000);
        random_traffic(100);
        // An inverted window lets nothing through.
        write_reg(CFG_MIN_DEPTH, 32'hFFFFFF);
        write_reg(CFG_MAX_DEPTH, 32'd0);
        random_traffic(35);
        write_reg(CFG_MIN_DEPTH, 32'd0);
        write_reg(CFG_MAX_DEPTH, 32'hFFFFFF);
        random_traffic(35);
    endtask

    task automatic test_pause_and_bursts();
        random_traffic(50);
        push <= 1'b0;
        while (expected_points.size() > 0) @(posedge i_clk);
        steady_send = 1'b1;
        steady_take = 1'b1;
        random_traffic(70);
        steady_take = 1'b0;
        random_traffic(70);
        steady_send = 1'b0;
        drain();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            pop <= 1'b0;
        end else if (steady_take) begin
            pop <= 1'b1;
        end else begin
            case ($urandom_range(0, 19))
                0: begin
                    stall_left <= $urandom_range(10, 50);
                    pop <= 1'b0;
                end
                1, 2, 3: pop <= 1'b0;
                default: pop <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            points_seen++;
            if (expected_points.size() == 0) begin
                $error("result with no point expected: %h", o_result);
                errors++;
            end else begin
                want = expected_points.pop_front();
                if (o_result.world_x !== want.world_x) begin
                    $error("world_x expected %h got %h", want.world_x, o_result.world_x);
                    errors++;
                end
                if (o_result.world_y !== want.world_y) begin
                    $error("world_y expected %h got %h", want.world_y, o_result.world_y);
                    errors++;
                end
                if (o_result.world_z !== want.world_z) begin
                    $error("world_z expected %h got %h", want.world_z, o_result.world_z);
                    errors++;
                end
                if (o_result.packed_color !== want.packed_color) begin
                    $error("packed_color expected %h got %h", want.packed_color,
                           o_result.packed_color);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_intrinsics();
        test_extremes();
        test_depth_window();
        test_pause_and_bursts();
        drain();
        if (expected_points.size() != 0) begin
            $error("%0d points never appeared", expected_points.size());
            errors++;
        end
        $display("sent %0d items, checked %0d world points, %0d register writes",
                 items_sent, points_seen, cfg_writes);
        $display("covered pose loads, dropped points, saturation and depth windows");
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/dpw_pkg.sv
rtl/core/dpw_ram.sv
rtl/core/dpw_front.sv
rtl/core/dpw_recip.sv
rtl/core/dpw_cam_div.sv
rtl/core/dpw_back.sv
rtl/core/depth_pixel_to_world_point.sv
sim/tb.sv
